// ===== design/lcpd_pkg.sv =====
// Shared types and constants for the line centroid PID motor drive block.
// Used by lcpd_ctrl, lcpd_dp and line_centroid_pid_motor_drive; depends on nothing.
package lcpd_pkg;

  localparam int NUM_SENSORS    = 8;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = SAMPLE_W + $clog2(NUM_SENSORS);
  localparam int WSUM_W   = SAMPLE_W + $clog2(NUM_SENSORS * (NUM_SENSORS - 1) / 2 + 1);
  localparam int SIDX_W   = $clog2(NUM_SENSORS);

  localparam int SCALE   = 1000;
  localparam int POS_MAX = (NUM_SENSORS - 1) * SCALE;
  localparam int CENTER  = (NUM_SENSORS - 1) * SCALE / 2;
  localparam int QUO_W   = $clog2(POS_MAX + 1);
  localparam int DVD_W   = WSUM_W + $clog2(SCALE);

  localparam int ERR_W   = 13;
  localparam int DER_W   = ERR_W + 1;
  localparam int INT_W   = 24;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 10;
  localparam int PWM_W   = 8;
  localparam int PWM_MAX = 255;
  localparam int PROD_W  = INT_W + GAIN_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int CTRL_W  = ACC_W - GAIN_FRAC_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MAC_TERMS = 3;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam logic [CNT_W-1:0] LAST_SENSOR   = CNT_W'(NUM_SENSORS - 1);
  localparam logic [CNT_W-1:0] LAST_DIV_STEP = CNT_W'(QUO_W - 1);
  localparam logic [CNT_W-1:0] LAST_MAC      = CNT_W'(MAC_TERMS - 1);

  // Index of each product term in the multiply-accumulate sequence.
  localparam logic [CNT_W-1:0] MAC_P = CNT_W'(0);
  localparam logic [CNT_W-1:0] MAC_I = CNT_W'(1);
  localparam logic [CNT_W-1:0] MAC_D = CNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_SPEED = 3'd0,
    REG_MIN_SPEED   = 3'd1,
    REG_MAX_SPEED   = 3'd2,
    REG_GAIN_P      = 3'd3,
    REG_GAIN_I      = 3'd4,
    REG_GAIN_D      = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_ERR,
    ST_INTEG,
    ST_MAC,
    ST_CTRL,
    ST_DRIVE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACCUM,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_ERR,
    OP_INTEG,
    OP_MAC,
    OP_CTRL,
    OP_DRIVE
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/lcpd_ctrl.sv =====
// Sequencer for the line centroid PID block: steps the datapath through one item.
// Depends on lcpd_pkg.
module lcpd_ctrl import lcpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.idx   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.op = OP_ACCUM;
        if (cnt_r == LAST_SENSOR) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV_LOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV_LOAD: begin
        cmd.op    = OP_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == LAST_DIV_STEP) begin
          cnt_nxt   = '0;
          state_nxt = ST_ERR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.op    = OP_INTEG;
        cnt_nxt   = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.op = OP_MAC;
        if (cnt_r == LAST_MAC) begin
          cnt_nxt   = '0;
          state_nxt = ST_CTRL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CTRL: begin
        cmd.op    = OP_CTRL;
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        // Wait until the output register can take the result.
        if (status.out_free) begin
          cmd.op    = OP_DRIVE;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/lcpd_dp.sv =====
// Datapath of the line centroid PID block: registers, sums, divider, MAC and drive limits.
// Depends on lcpd_pkg; driven by lcpd_ctrl through dp_cmd_t.
module lcpd_dp import lcpd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_status_t                   status,
  input  logic [SAMPLE_W-1:0]          sensors [NUM_SENSORS],
  input  logic                         cfg_valid,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_dir_a,
  output logic [PWM_W-1:0]             out_pwm_a,
  output logic                         out_dir_b,
  output logic [PWM_W-1:0]             out_pwm_b,
  output logic signed [ERR_W-1:0]      out_line_error
);

  localparam logic [ACC_W-1:0] ROUND_UP = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  // Configuration registers.
  logic signed [SPEED_W-1:0] drive_r, min_r, max_r;
  logic signed [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;

  // Working registers.
  logic [SAMPLE_W-1:0]       smp_r [NUM_SENSORS];
  logic [SUM_W-1:0]          sum_r;
  logic [WSUM_W-1:0]         wsum_r;
  logic [SUM_W-1:0]          rem_r;
  logic [QUO_W-1:0]          quo_r;
  logic signed [ERR_W-1:0]   err_r, prev_r;
  logic signed [INT_W-1:0]   integ_r;
  logic signed [DER_W-1:0]   deriv_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [CTRL_W-1:0]  ctrl_r;
  logic                      out_valid_r;
  logic                      dir_a_r, dir_b_r;
  logic [PWM_W-1:0]          pwm_a_r, pwm_b_r;
  logic signed [ERR_W-1:0]   line_err_r;

  // Combinational terms.
  logic [SIDX_W-1:0]         sidx;
  logic [DVD_W-1:0]          dividend;
  logic [SUM_W:0]            trial;
  logic                      trial_ge;
  logic signed [QUO_W+1:0]   pos_err;
  logic signed [INT_W:0]     integ_sum;
  logic signed [INT_W-1:0]   integ_sat;
  logic signed [INT_W-1:0]   mac_a;
  logic signed [GAIN_W-1:0]  mac_b;
  logic signed [PROD_W-1:0]  product;
  logic signed [ACC_W-1:0]   acc_adj;
  logic signed [CTRL_W:0]    speed_a, speed_b;
  logic signed [SPEED_W-1:0] lim_a, lim_b;

  // Lower bound is tested first, so an inverted pair yields min below min and max otherwise.
  function automatic logic signed [SPEED_W-1:0] clamp_speed(
    input logic signed [CTRL_W:0]    x,
    input logic signed [SPEED_W-1:0] lo,
    input logic signed [SPEED_W-1:0] hi
  );
    logic signed [CTRL_W:0] lo_w;
    logic signed [CTRL_W:0] hi_w;
    lo_w = (CTRL_W+1)'(lo);
    hi_w = (CTRL_W+1)'(hi);
    if (x < lo_w) begin
      return lo;
    end else if (x > hi_w) begin
      return hi;
    end
    return x[SPEED_W-1:0];
  endfunction

  function automatic logic [PWM_W:0] drive_bits(input logic signed [SPEED_W-1:0] s);
    logic signed [SPEED_W-1:0] lim;
    logic signed [SPEED_W-1:0] mag;
    if (s < -SPEED_W'(PWM_MAX)) begin
      lim = -SPEED_W'(PWM_MAX);
    end else if (s > SPEED_W'(PWM_MAX)) begin
      lim = SPEED_W'(PWM_MAX);
    end else begin
      lim = s;
    end
    mag = (lim < 0) ? -lim : lim;
    return {(lim > 0), mag[PWM_W-1:0]};
  endfunction

  assign sidx     = cmd.idx[SIDX_W-1:0];
  assign dividend = DVD_W'(wsum_r) * DVD_W'(SCALE);
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, sum_r};
  assign pos_err  = $signed({2'b00, quo_r}) - (QUO_W+2)'(CENTER);

  // Saturating 24-bit integral update: overflow when the two top bits differ.
  assign integ_sum = (INT_W+1)'(integ_r) + (INT_W+1)'(err_r);
  always_comb begin
    if (integ_sum[INT_W] != integ_sum[INT_W-1]) begin
      integ_sat = integ_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INT_W-1:0];
    end
  end

  always_comb begin
    case (cmd.idx)
      MAC_P: begin
        mac_a = INT_W'(err_r);
        mac_b = gain_p_r;
      end
      MAC_I: begin
        mac_a = integ_r;
        mac_b = gain_i_r;
      end
      MAC_D: begin
        mac_a = INT_W'(deriv_r);
        mac_b = gain_d_r;
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end
  assign product = PROD_W'(mac_a) * PROD_W'(mac_b);

  // Floor of (acc + 2^F - 1) / 2^F for negative acc gives truncation toward zero.
  assign acc_adj = acc_r + (acc_r[ACC_W-1] ? $signed(ROUND_UP) : $signed(ACC_W'(0)));

  assign speed_a = (CTRL_W+1)'(drive_r) + (CTRL_W+1)'(ctrl_r);
  assign speed_b = (CTRL_W+1)'(drive_r) - (CTRL_W+1)'(ctrl_r);
  assign lim_a   = clamp_speed(speed_a, min_r, max_r);
  assign lim_b   = clamp_speed(speed_b, min_r, max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r  <= '0;
      min_r    <= -SPEED_W'(PWM_MAX);
      max_r    <= SPEED_W'(PWM_MAX);
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DRIVE_SPEED: drive_r  <= cfg_data[SPEED_W-1:0];
        REG_MIN_SPEED:   min_r    <= cfg_data[SPEED_W-1:0];
        REG_MAX_SPEED:   max_r    <= cfg_data[SPEED_W-1:0];
        REG_GAIN_P:      gain_p_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:      gain_i_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:      gain_d_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
    end else if (cmd.op == OP_INTEG) begin
      prev_r  <= err_r;
      integ_r <= integ_sat;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        smp_r  <= sensors;
        sum_r  <= '0;
        wsum_r <= '0;
      end
      OP_ACCUM: begin
        sum_r  <= sum_r + SUM_W'(smp_r[sidx]);
        wsum_r <= wsum_r + WSUM_W'(smp_r[sidx]) * WSUM_W'(sidx);
      end
      OP_DIV_LOAD: begin
        rem_r <= SUM_W'(dividend >> QUO_W);
        quo_r <= dividend[QUO_W-1:0];
      end
      OP_DIV_STEP: begin
        rem_r <= trial_ge ? SUM_W'(trial - {1'b0, sum_r}) : trial[SUM_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], trial_ge};
      end
      OP_ERR: begin
        err_r <= (sum_r == '0) ? prev_r : pos_err[ERR_W-1:0];
      end
      OP_INTEG: begin
        deriv_r <= DER_W'(err_r) - DER_W'(prev_r);
        acc_r   <= '0;
      end
      OP_MAC: begin
        acc_r <= acc_r + ACC_W'(product);
      end
      OP_CTRL: begin
        ctrl_r <= acc_adj[ACC_W-1:GAIN_FRAC_BITS];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_DRIVE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DRIVE) begin
      {dir_a_r, pwm_a_r} <= drive_bits(lim_a);
      {dir_b_r, pwm_b_r} <= drive_bits(lim_b);
      line_err_r         <= err_r;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_dir_a       = dir_a_r;
  assign out_pwm_a       = pwm_a_r;
  assign out_dir_b       = dir_b_r;
  assign out_pwm_b       = pwm_b_r;
  assign out_line_error  = line_err_r;

endmodule

// ===== design/line_centroid_pid_motor_drive.sv =====
// Top level of the line follower: weighted centroid, PID step and two motor drives.
// Depends on lcpd_pkg, lcpd_ctrl and lcpd_dp.
//
//   Channel   Signals                                     Direction
//   input     in_valid/in_ready, in_sensor_0..7           one sensor set per transfer
//   result    out_valid/out_ready, out_dir_a/b, out_pwm_a/b, out_line_error
//   config    cfg_valid/cfg_ready, cfg_index, cfg_data    register writes, always ready
//
// An item goes from its transfer to its result in the output register in these steps:
// one cycle per sensor to form the sums, a restoring divider that retires one
// quotient bit per cycle (13 bits), and a shared multiplier that accumulates the
// three PID products one per cycle. The next item is taken in the cycle after the
// result enters the output register, so items never overlap. A stalled consumer holds
// that register; the next result then waits in the drive state and input is refused.
// Reset (rst_n low at a clock edge) clears the state, out_valid, the PID history
// and the configuration registers to their defaults; other registers are not reset.
module line_centroid_pid_motor_drive import lcpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_W-1:0]     in_sensor_0,
  input  logic [SAMPLE_W-1:0]     in_sensor_1,
  input  logic [SAMPLE_W-1:0]     in_sensor_2,
  input  logic [SAMPLE_W-1:0]     in_sensor_3,
  input  logic [SAMPLE_W-1:0]     in_sensor_4,
  input  logic [SAMPLE_W-1:0]     in_sensor_5,
  input  logic [SAMPLE_W-1:0]     in_sensor_6,
  input  logic [SAMPLE_W-1:0]     in_sensor_7,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_dir_a,
  output logic [PWM_W-1:0]        out_pwm_a,
  output logic                    out_dir_b,
  output logic [PWM_W-1:0]        out_pwm_b,
  output logic signed [ERR_W-1:0] out_line_error,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic [SAMPLE_W-1:0] sensors [NUM_SENSORS];

  // Sensor ports gathered into one array, position order.
  assign sensors[0] = in_sensor_0;
  assign sensors[1] = in_sensor_1;
  assign sensors[2] = in_sensor_2;
  assign sensors[3] = in_sensor_3;
  assign sensors[4] = in_sensor_4;
  assign sensors[5] = in_sensor_5;
  assign sensors[6] = in_sensor_6;
  assign sensors[7] = in_sensor_7;

  // Configuration writes are registered directly, so the port never stalls.
  assign cfg_ready = 1'b1;

  lcpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lcpd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .sensors        (sensors),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dir_a      (out_dir_a),
    .out_pwm_a      (out_pwm_a),
    .out_dir_b      (out_dir_b),
    .out_pwm_b      (out_pwm_b),
    .out_line_error (out_line_error)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for line_centroid_pid_motor_drive: sends sensor sets and register
// writes, predicts each motor drive result in its own model and compares it field by field.
// Depends on lcpd_pkg and the design files only.
module tb;
  import lcpd_pkg::*;

  // One sensor set, sensor 7 in the top slice. Packed so it passes cleanly through tasks.
  typedef logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] sensor_set_t;

  typedef struct packed {
    logic                    dir_a;
    logic [PWM_W-1:0]        pwm_a;
    logic                    dir_b;
    logic [PWM_W-1:0]        pwm_b;
    logic signed [ERR_W-1:0] line_error;
  } drive_result_t;

  // Register indexes that decode to nothing; writes to them must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

  // Line geometry: sensors sit 1000 position units apart, the center is between 3 and 4.
  localparam int POS_STEP   = 1000;
  localparam int POS_CENTER = 3500;
  localparam longint INTEG_HI = 64'sd8388607;
  localparam longint INTEG_LO = -64'sd8388608;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] in_sensor_0 = '0;
  logic [SAMPLE_W-1:0] in_sensor_1 = '0;
  logic [SAMPLE_W-1:0] in_sensor_2 = '0;
  logic [SAMPLE_W-1:0] in_sensor_3 = '0;
  logic [SAMPLE_W-1:0] in_sensor_4 = '0;
  logic [SAMPLE_W-1:0] in_sensor_5 = '0;
  logic [SAMPLE_W-1:0] in_sensor_6 = '0;
  logic [SAMPLE_W-1:0] in_sensor_7 = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_dir_a;
  logic [PWM_W-1:0]        out_pwm_a;
  logic                    out_dir_b;
  logic [PWM_W-1:0]        out_pwm_b;
  logic signed [ERR_W-1:0] out_line_error;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  line_centroid_pid_motor_drive dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sensor_0    (in_sensor_0),
    .in_sensor_1    (in_sensor_1),
    .in_sensor_2    (in_sensor_2),
    .in_sensor_3    (in_sensor_3),
    .in_sensor_4    (in_sensor_4),
    .in_sensor_5    (in_sensor_5),
    .in_sensor_6    (in_sensor_6),
    .in_sensor_7    (in_sensor_7),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dir_a      (out_dir_a),
    .out_pwm_a      (out_pwm_a),
    .out_dir_b      (out_dir_b),
    .out_pwm_b      (out_pwm_b),
    .out_line_error (out_line_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the block's settings and PID history, kept at the block's own widths.
  // The initial values match what reset leaves in the block.
  logic signed [SPEED_W-1:0] base_speed  = '0;
  logic signed [SPEED_W-1:0] floor_speed = SPEED_W'(-255);
  logic signed [SPEED_W-1:0] ceil_speed  = SPEED_W'(255);
  logic signed [GAIN_W-1:0]  kp = '0;
  logic signed [GAIN_W-1:0]  ki = '0;
  logic signed [GAIN_W-1:0]  kd = '0;
  logic signed [ERR_W-1:0]   last_error = '0;
  logic signed [INT_W-1:0]   err_sum = '0;

  // Drive results still owed by the block, oldest first.
  drive_result_t pending_drive[$];
  int drive_mismatches = 0;

  // Idling control shared by the sender and the result sink. With idle_on low both sides
  // run flat out. hold_request asks the sink for one long stall of that many cycles.
  bit idle_on = 1'b1;
  int hold_request = 0;
  bit hold_active = 1'b0;

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 80);
  endfunction

  // Clamp to the configured window (lower bound tested first, so an inverted window yields
  // min below min, else max), then to the PWM range; split into direction bit and magnitude.
  function automatic void motor_cmd(input longint speed, output logic dir,
                                    output logic [PWM_W-1:0] pwm);
    longint v;
    v = speed;
    if (v < floor_speed) v = floor_speed;
    else if (v > ceil_speed) v = ceil_speed;
    if (v < -PWM_MAX) v = -PWM_MAX;
    else if (v > PWM_MAX) v = PWM_MAX;
    dir = v > 0;
    pwm = PWM_W'((v < 0) ? -v : v);
  endfunction

  // Centroid, error, one PID step and both motor commands for one sensor set. Updates the
  // shadow PID history, so it is called exactly once per accepted set, in order.
  function automatic drive_result_t predict_drive(input sensor_set_t s);
    longint sample_total, weighted_total, err, integ, slope, acc, ctrl;
    drive_result_t r;
    int i;
    sample_total = 0;
    weighted_total = 0;
    for (i = 0; i < NUM_SENSORS; i++) begin
      sample_total += longint'(s[i]);
      weighted_total += longint'(s[i]) * i * POS_STEP;
    end
    // A dark array gives no position; the last error is reused.
    if (sample_total > 0) err = weighted_total / sample_total - POS_CENTER;
    else err = last_error;
    integ = err_sum + err;
    if (integ > INTEG_HI) integ = INTEG_HI;
    if (integ < INTEG_LO) integ = INTEG_LO;
    slope = err - last_error;
    acc = err * kp + integ * ki + slope * kd;
    // Drop the gain fraction, rounding toward zero.
    ctrl = (acc < 0) ? -((-acc) >>> GAIN_FRAC_BITS) : (acc >>> GAIN_FRAC_BITS);
    err_sum = integ[INT_W-1:0];
    last_error = err[ERR_W-1:0];
    motor_cmd(base_speed + ctrl, r.dir_a, r.pwm_a);
    motor_cmd(base_speed - ctrl, r.dir_b, r.pwm_b);
    r.line_error = err[ERR_W-1:0];
    return r;
  endfunction

  function automatic sensor_set_t one_hot_set(input int pos, input int level);
    sensor_set_t s;
    s = '0;
    s[pos] = level[SAMPLE_W-1:0];
    return s;
  endfunction

  // Mostly line-like sets (a bright peak with weaker neighbors on a dim floor), plus fully
  // random sets, single lit sensors and the occasional dark array.
  function automatic sensor_set_t random_set();
    sensor_set_t s;
    int kind, peak, i;
    s = '0;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      s = '0;
    end else if (kind < 35) begin
      for (i = 0; i < NUM_SENSORS; i++) s[i] = SAMPLE_W'($urandom_range(0, 1023));
    end else if (kind < 45) begin
      s[$urandom_range(0, NUM_SENSORS - 1)] = SAMPLE_W'($urandom_range(1, 1023));
    end else begin
      peak = $urandom_range(0, NUM_SENSORS - 1);
      for (i = 0; i < NUM_SENSORS; i++) s[i] = SAMPLE_W'($urandom_range(0, 40));
      s[peak] = SAMPLE_W'($urandom_range(600, 1023));
      if (peak > 0) s[peak - 1] = SAMPLE_W'($urandom_range(0, 700));
      if (peak < NUM_SENSORS - 1) s[peak + 1] = SAMPLE_W'($urandom_range(0, 700));
    end
    return s;
  endfunction

  // Mostly modest gains so the control term lands inside the speed range, sometimes any
  // 16-bit value.
  function automatic int rand_gain(input int lim);
    if ($urandom_range(0, 4) == 0) return rand_between(-32768, 32767);
    return rand_between(-lim, lim);
  endfunction

  // Speed registers take only the low 10 bits; the rest of the data word is noise.
  function automatic logic [CFG_DATA_W-1:0] pad_speed(input int v);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom);
    w[SPEED_W-1:0] = v[SPEED_W-1:0];
    return w;
  endfunction

  function automatic void compare_field(input string field, input longint want,
                                        input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      drive_mismatches++;
    end
  endfunction

  // One register write. cfg_valid is left high so that back-to-back writes keep it high;
  // apply_settings lowers it after the last one. The shadow copy changes on the transfer.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DRIVE_SPEED: base_speed  = data[SPEED_W-1:0];
      REG_MIN_SPEED:   floor_speed = data[SPEED_W-1:0];
      REG_MAX_SPEED:   ceil_speed  = data[SPEED_W-1:0];
      REG_GAIN_P:      kp = data;
      REG_GAIN_I:      ki = data;
      REG_GAIN_D:      kd = data;
      default: ;
    endcase
  endtask

  // Writes every register, bracketed by writes to both unmapped indexes. Only called while
  // the block is idle.
  task automatic apply_settings(input int speed, input int lo, input int hi,
                                input int p, input int i, input int d);
    write_reg(REG_UNMAPPED_6, CFG_DATA_W'($urandom));
    write_reg(REG_DRIVE_SPEED, pad_speed(speed));
    write_reg(REG_MIN_SPEED, pad_speed(lo));
    write_reg(REG_MAX_SPEED, pad_speed(hi));
    write_reg(REG_GAIN_P, p[CFG_DATA_W-1:0]);
    write_reg(REG_GAIN_I, i[CFG_DATA_W-1:0]);
    write_reg(REG_GAIN_D, d[CFG_DATA_W-1:0]);
    write_reg(REG_UNMAPPED_7, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Offers one sensor set and waits for its transfer. Valid is lowered only when a gap is
  // taken, so a set that follows without a gap keeps valid high across the edge.
  task automatic send_set(input sensor_set_t s);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_sensor_7, in_sensor_6, in_sensor_5, in_sensor_4,
     in_sensor_3, in_sensor_2, in_sensor_1, in_sensor_0} <= s;
    do @(posedge clk); while (!in_ready);
    pending_drive.push_back(predict_drive(s));
  endtask

  // Stop offering and wait until every owed result has been taken, leaving the block idle.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  // Reset settings: all gains zero, so both motors stay stopped and only the error moves.
  // Covers the dark array straight after reset, both ends of the array, the dark array
  // holding a nonzero error, and full-scale and alternating-bit samples.
  task automatic test_reset_defaults();
    send_set('0);
    send_set(one_hot_set(0, 1023));
    send_set(one_hot_set(7, 1023));
    send_set('0);
    send_set({NUM_SENSORS{10'h3FF}});
    send_set({NUM_SENSORS{10'h2AA}});
    send_set({NUM_SENSORS{10'h155}});
    send_set(one_hot_set(4, 1));
    finish_phase();
  endtask

  // A few hand-picked settings: a normal window, an inverted window where min_speed is
  // above max_speed, and a window pinned at zero so both motors report a stopped drive.
  task automatic test_directed_drive();
    sensor_set_t centered;
    centered = '0;
    centered[3] = SAMPLE_W'(700);
    centered[4] = SAMPLE_W'(700);
    apply_settings(100, -255, 255, 64, 2, 128);
    send_set(one_hot_set(0, 1023));
    send_set(one_hot_set(7, 512));
    send_set('0);
    send_set('0);
    send_set(centered);
    finish_phase();
    apply_settings(40, 120, -120, 256, 0, -256);
    send_set(one_hot_set(2, 300));
    send_set(one_hot_set(6, 900));
    send_set(one_hot_set(5, 1));
    finish_phase();
    apply_settings(0, 0, 0, 32767, 32767, 32767);
    send_set(one_hot_set(7, 1023));
    send_set(one_hot_set(0, 1023));
    finish_phase();
  endtask

  // The sink stops taking results for a long stretch while sets keep coming, so the block
  // holds one result, finishes the next and then has to refuse further input.
  task automatic test_output_stall();
    int n;
    hold_request = 300;
    wait (hold_active);
    for (n = 0; n < 6; n++) send_set(random_set());
    finish_phase();
  endtask

  // Winds the integral up with the line at one edge of the array, down past zero with the
  // line at the other edge, and back again. With an integral gain of 1/256 the control term
  // follows the integral over 256, so both motors sweep the whole window in both directions.
  task automatic test_integral_windup();
    int n;
    idle_on = 1'b0;
    apply_settings(0, -511, 511, 0, 1, 0);
    for (n = 0; n < 60; n++) send_set(one_hot_set(7, $urandom_range(1, 1023)));
    for (n = 0; n < 120; n++) send_set(one_hot_set(0, $urandom_range(1, 1023)));
    for (n = 0; n < 60; n++) send_set(one_hot_set(7, $urandom_range(1, 1023)));
    finish_phase();
    idle_on = 1'b1;
  endtask

  // Random sets under a sequence of settings: the two extreme corners first, then random
  // windows (sometimes inverted) and gains. Every fourth phase runs without idling.
  task automatic test_random_phases();
    int ph, n;
    for (ph = 0; ph < 10; ph++) begin
      idle_on = (ph % 4) != 3;
      case (ph)
        0: apply_settings(511, -511, 511, 32767, -32768, 32767);
        1: apply_settings(-511, 511, -511, -32768, 32767, -32768);
        default: apply_settings(rand_between(-300, 300), rand_between(-511, 200),
                                rand_between(-200, 511), rand_gain(64), rand_gain(4),
                                rand_gain(128));
      endcase
      for (n = 0; n < 48; n++) send_set(random_set());
      finish_phase();
    end
    idle_on = 1'b1;
  endtask

  // Result sink: bursts of ready separated by random gaps, or one long hold on request.
  // Every change of out_ready is followed by at least one clock edge.
  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        n = idle_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Result checker: every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        $display("%0t: result with none expected, actual dir_a=%0d pwm_a=%0d", $time,
                 out_dir_a, out_pwm_a);
        $display("%0t:   dir_b=%0d pwm_b=%0d line_error=%0d", $time,
                 out_dir_b, out_pwm_b, out_line_error);
        drive_mismatches++;
      end else begin
        want = pending_drive.pop_front();
        compare_field("dir_a", want.dir_a, out_dir_a);
        compare_field("pwm_a", want.pwm_a, out_pwm_a);
        compare_field("dir_b", want.dir_b, out_dir_b);
        compare_field("pwm_b", want.pwm_b, out_pwm_b);
        compare_field("line_error", want.line_error, out_line_error);
      end
    end
  end

  // Main sequence. Reset is held from time zero and released once; every test leaves the
  // block idle so the next one may rewrite the registers.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_drive();
    test_output_stall();
    test_integral_windup();
    test_random_phases();
    // Give a stray extra result time to show up before the verdict.
    repeat (40) @(posedge clk);
    if (drive_mismatches == 0) begin
      $display("line_centroid_pid_motor_drive regression: pass");
    end else begin
      $display("line_centroid_pid_motor_drive regression: fail");
    end
    $finish;
  end

  // Watchdog: ends the run with a failure if the main sequence has not finished.
  initial begin
    #20_000_000;
    $display("line_centroid_pid_motor_drive regression: fail");
    $finish;
  end

endmodule

// ===== line_centroid_pid_motor_drive.f =====
design/lcpd_pkg.sv
design/lcpd_ctrl.sv
design/lcpd_dp.sv
design/line_centroid_pid_motor_drive.sv
test/tb.sv
